@@ design/tbp_pkg.sv @@
package tbp_pkg;

  localparam int unsigned WORD_BITS     = 32;
  localparam int unsigned FRACTION_BITS = 30;

  // Per-item status that travels beside the two division lanes
  typedef struct packed {
    logic degenerate;
    logic neg_up;
    logic neg_mid;
    logic ovf_up;
    logic ovf_mid;
  } tbp_flags_t;

  function automatic int unsigned max_u(input int unsigned a, input int unsigned b);
    return (a > b) ? a : b;
  endfunction

endpackage

@@ design/tbp_if.sv @@
interface tbp_in_if #(
  parameter int unsigned WordBits = tbp_pkg::WORD_BITS
);
  logic                       valid;
  logic                       ready;
  logic signed [WordBits-1:0] son_up_value;
  logic signed [WordBits-1:0] son_mid_value;
  logic signed [WordBits-1:0] son_down_value;
  logic signed [WordBits-1:0] expected_value;
  logic        [WordBits-2:0] local_variance;

  modport source (
    output valid, son_up_value, son_mid_value, son_down_value, expected_value, local_variance,
    input  ready
  );
  modport sink (
    input  valid, son_up_value, son_mid_value, son_down_value, expected_value, local_variance,
    output ready
  );
endinterface

interface tbp_out_if #(
  parameter int unsigned WordBits = tbp_pkg::WORD_BITS
);
  logic                       valid;
  logic                       ready;
  logic signed [WordBits-1:0] prob_up;
  logic signed [WordBits-1:0] prob_mid;
  logic signed [WordBits-1:0] prob_down;
  logic                       negative_flag;
  logic                       degenerate_flag;

  modport source (
    output valid, prob_up, prob_mid, prob_down, negative_flag, degenerate_flag,
    input  ready
  );
  modport sink (
    input  valid, prob_up, prob_mid, prob_down, negative_flag, degenerate_flag,
    output ready
  );
endinterface

@@ design/tbp_front.sv @@
module tbp_front #(
  parameter int unsigned WordBits     = tbp_pkg::WORD_BITS,
  parameter int unsigned FractionBits = tbp_pkg::FRACTION_BITS,
  parameter int unsigned ProdBits     = 2 * (WordBits + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic signed [WordBits-1:0] son_up_i,
  input  logic signed [WordBits-1:0] son_mid_i,
  input  logic signed [WordBits-1:0] son_down_i,
  input  logic signed [WordBits-1:0] expected_i,
  input  logic        [WordBits-2:0] variance_i,
  output logic                       valid_o,
  output tbp_pkg::tbp_flags_t        flags_o,
  output logic        [ProdBits-1:0] rem_up_o,
  output logic        [WordBits-1:0] nq_up_o,
  output logic        [ProdBits-1:0] div_up_o,
  output logic        [ProdBits-1:0] rem_mid_o,
  output logic        [WordBits-1:0] nq_mid_o,
  output logic        [ProdBits-1:0] div_mid_o
);
  import tbp_pkg::*;

  localparam int unsigned DiffBits = WordBits + 1;
  localparam int unsigned VsBits   = WordBits - 1 + FractionBits;
  localparam int unsigned SumBits  = max_u(ProdBits, VsBits + 1) + 1;
  localparam int unsigned NumBits  = SumBits + FractionBits;
  localparam int unsigned HiBits   = NumBits - WordBits;
  localparam int unsigned CmpBits  = max_u(HiBits, ProdBits);

  // Stage 1: differences
  logic                       v1_q;
  logic                       deg1_q;
  logic signed [DiffBits-1:0] xu_q, xm_q, xd_q, dum_q, dud_q, dmu_q, dmd_q;
  logic        [WordBits-2:0] var1_q;

  // Stage 2: products
  logic                       v2_q;
  logic                       deg2_q;
  logic signed [ProdBits-1:0] pn_up_q, pn_mid_q, pd_up_q, pd_mid_q;
  logic        [WordBits-2:0] var2_q;

  // Stage 3: numerators, magnitudes
  logic                       v3_q;
  logic                       deg3_q;
  logic        [NumBits-1:0]  na_up_q, na_mid_q;
  logic        [ProdBits-1:0] da_up_q, da_mid_q;
  logic                       neg_up_q, neg_mid_q;

  logic signed [SumBits-1:0]  vs;
  logic signed [SumBits-1:0]  sum_up, sum_mid;
  logic signed [NumBits-1:0]  num_up, num_mid;
  logic        [HiBits-1:0]   hi_up, hi_mid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v1_q    <= valid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg1_q <= (son_up_i == son_mid_i) || (son_up_i == son_down_i) ||
                (son_mid_i == son_down_i);
      xu_q   <= DiffBits'(son_up_i) - DiffBits'(expected_i);
      xm_q   <= DiffBits'(son_mid_i) - DiffBits'(expected_i);
      xd_q   <= DiffBits'(son_down_i) - DiffBits'(expected_i);
      dum_q  <= DiffBits'(son_up_i) - DiffBits'(son_mid_i);
      dud_q  <= DiffBits'(son_up_i) - DiffBits'(son_down_i);
      dmu_q  <= DiffBits'(son_mid_i) - DiffBits'(son_up_i);
      dmd_q  <= DiffBits'(son_mid_i) - DiffBits'(son_down_i);
      var1_q <= variance_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg2_q   <= deg1_q;
      pn_up_q  <= ProdBits'(xm_q) * ProdBits'(xd_q);
      pn_mid_q <= ProdBits'(xu_q) * ProdBits'(xd_q);
      pd_up_q  <= ProdBits'(dum_q) * ProdBits'(dud_q);
      pd_mid_q <= ProdBits'(dmu_q) * ProdBits'(dmd_q);
      var2_q   <= var1_q;
    end
  end

  always_comb begin
    vs      = signed'(SumBits'({var2_q, {FractionBits{1'b0}}}));
    sum_up  = vs + SumBits'(pn_up_q);
    sum_mid = vs + SumBits'(pn_mid_q);
    num_up  = signed'({sum_up, {FractionBits{1'b0}}});
    num_mid = signed'({sum_mid, {FractionBits{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg3_q    <= deg2_q;
      na_up_q   <= num_up[NumBits-1] ? NumBits'(-num_up) : NumBits'(num_up);
      na_mid_q  <= num_mid[NumBits-1] ? NumBits'(-num_mid) : NumBits'(num_mid);
      da_up_q   <= pd_up_q[ProdBits-1] ? ProdBits'(-pd_up_q) : ProdBits'(pd_up_q);
      da_mid_q  <= pd_mid_q[ProdBits-1] ? ProdBits'(-pd_mid_q) : ProdBits'(pd_mid_q);
      neg_up_q  <= num_up[NumBits-1] ^ pd_up_q[ProdBits-1];
      neg_mid_q <= num_mid[NumBits-1] ^ pd_mid_q[ProdBits-1];
    end
  end

  assign hi_up  = na_up_q[NumBits-1:WordBits];
  assign hi_mid = na_mid_q[NumBits-1:WordBits];

  // Stage 4: quotient range check, seed the division chain
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_o.degenerate <= deg3_q;
      flags_o.neg_up     <= neg_up_q;
      flags_o.neg_mid    <= neg_mid_q;
      flags_o.ovf_up     <= CmpBits'(hi_up) >= CmpBits'(da_up_q);
      flags_o.ovf_mid    <= CmpBits'(hi_mid) >= CmpBits'(da_mid_q);
      rem_up_o           <= ProdBits'(hi_up);
      rem_mid_o          <= ProdBits'(hi_mid);
      nq_up_o            <= na_up_q[WordBits-1:0];
      nq_mid_o           <= na_mid_q[WordBits-1:0];
      div_up_o           <= da_up_q;
      div_mid_o          <= da_mid_q;
    end
  end

endmodule

@@ design/tbp_div_cell.sv @@
module tbp_div_cell #(
  parameter int unsigned WordBits = tbp_pkg::WORD_BITS,
  parameter int unsigned ProdBits = 2 * (WordBits + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  tbp_pkg::tbp_flags_t flags_i,
  input  logic [ProdBits-1:0] rem_up_i,
  input  logic [WordBits-1:0] nq_up_i,
  input  logic [ProdBits-1:0] div_up_i,
  input  logic [ProdBits-1:0] rem_mid_i,
  input  logic [WordBits-1:0] nq_mid_i,
  input  logic [ProdBits-1:0] div_mid_i,
  output logic                valid_o,
  output tbp_pkg::tbp_flags_t flags_o,
  output logic [ProdBits-1:0] rem_up_o,
  output logic [WordBits-1:0] nq_up_o,
  output logic [ProdBits-1:0] div_up_o,
  output logic [ProdBits-1:0] rem_mid_o,
  output logic [WordBits-1:0] nq_mid_o,
  output logic [ProdBits-1:0] div_mid_o
);
  import tbp_pkg::*;

  // One restoring step: pull in the next dividend bit, shift the quotient
  // bit into the freed low end of the same word.
  function automatic logic [ProdBits+WordBits-1:0] div_step(
    input logic [ProdBits-1:0] rem,
    input logic [WordBits-1:0] nq,
    input logic [ProdBits-1:0] dv
  );
    logic [ProdBits:0]   r2;
    logic                ge;
    logic [ProdBits-1:0] rn;
    r2 = {rem, nq[WordBits-1]};
    ge = r2 >= {1'b0, dv};
    rn = ge ? ProdBits'(r2 - {1'b0, dv}) : r2[ProdBits-1:0];
    return {rn, nq[WordBits-2:0], ge};
  endfunction

  logic [ProdBits+WordBits-1:0] step_up, step_mid;

  assign step_up  = div_step(rem_up_i, nq_up_i, div_up_i);
  assign step_mid = div_step(rem_mid_i, nq_mid_i, div_mid_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      flags_o               <= flags_i;
      {rem_up_o, nq_up_o}   <= step_up;
      {rem_mid_o, nq_mid_o} <= step_mid;
      div_up_o              <= div_up_i;
      div_mid_o             <= div_mid_i;
    end
  end

endmodule

@@ design/tbp_finish.sv @@
module tbp_finish #(
  parameter int unsigned WordBits     = tbp_pkg::WORD_BITS,
  parameter int unsigned FractionBits = tbp_pkg::FRACTION_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  tbp_pkg::tbp_flags_t        flags_i,
  input  logic        [WordBits-1:0] q_up_i,
  input  logic        [WordBits-1:0] q_mid_i,
  output logic                       valid_o,
  output logic signed [WordBits-1:0] prob_up_o,
  output logic signed [WordBits-1:0] prob_mid_o,
  output logic signed [WordBits-1:0] prob_down_o,
  output logic                       negative_o,
  output logic                       degenerate_o
);
  import tbp_pkg::*;

  localparam int unsigned PdBits = max_u(WordBits, FractionBits + 1) + 2;

  localparam logic signed [WordBits-1:0] MaxVal = {1'b0, {(WordBits-1){1'b1}}};
  localparam logic signed [WordBits-1:0] MinVal = {1'b1, {(WordBits-1){1'b0}}};
  localparam logic signed [PdBits-1:0]   One    = PdBits'(1) << FractionBits;

  function automatic logic signed [WordBits-1:0] sat_q(
    input logic [WordBits-1:0] q,
    input logic                neg,
    input logic                ovf
  );
    logic signed [WordBits-1:0] r;
    if (ovf) begin
      r = neg ? MinVal : MaxVal;
    end else if (neg) begin
      r = (q > MinVal) ? MinVal : WordBits'(-q);
    end else begin
      r = q[WordBits-1] ? MaxVal : q;
    end
    return r;
  endfunction

  logic signed [WordBits-1:0] pu, pm, pd;
  logic signed [PdBits-1:0]   pd_w;

  always_comb begin
    pu   = sat_q(q_up_i, flags_i.neg_up, flags_i.ovf_up);
    pm   = sat_q(q_mid_i, flags_i.neg_mid, flags_i.ovf_mid);
    pd_w = One - PdBits'(pu) - PdBits'(pm);
    if (pd_w > PdBits'(MaxVal)) begin
      pd = MaxVal;
    end else if (pd_w < PdBits'(MinVal)) begin
      pd = MinVal;
    end else begin
      pd = WordBits'(pd_w);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // Coincident sons: zero everything, raise only the degenerate flag
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      degenerate_o <= flags_i.degenerate;
      if (flags_i.degenerate) begin
        prob_up_o   <= '0;
        prob_mid_o  <= '0;
        prob_down_o <= '0;
        negative_o  <= 1'b0;
      end else begin
        prob_up_o   <= pu;
        prob_mid_o  <= pm;
        prob_down_o <= pd;
        negative_o  <= pu[WordBits-1] | pm[WordBits-1] | pd[WordBits-1];
      end
    end
  end

endmodule

@@ design/trinomial_branch_probabilities_top.sv @@
// Channel  Dir  Payload
// in_i     in   son_up_value, son_mid_value, son_down_value, expected_value, local_variance
// out_o    out  prob_up, prob_mid, prob_down, negative_flag, degenerate_flag
//
// One node per cycle while out_o is not stalled; the pipeline has four setup
// stages, one chain cell per quotient bit and one output stage. The division chain sets its depth.
// Reset clears only the valid bits of the stages.
// A stalled output freezes the whole pipeline; in_i.ready follows
// out_o.ready whenever the output register holds a result.
module trinomial_branch_probabilities_top #(
  parameter int unsigned WordBits     = tbp_pkg::WORD_BITS,
  parameter int unsigned FractionBits = tbp_pkg::FRACTION_BITS
) (
  input logic      clk_i,
  input logic      rst_ni,
  tbp_in_if.sink   in_i,
  tbp_out_if.source out_o
);
  import tbp_pkg::*;

  localparam int unsigned ProdBits = 2 * (WordBits + 1);

  logic en;

  logic                cv     [WordBits+1];
  tbp_flags_t          cf     [WordBits+1];
  logic [ProdBits-1:0] crem_u [WordBits+1];
  logic [WordBits-1:0] cnq_u  [WordBits+1];
  logic [ProdBits-1:0] cdiv_u [WordBits+1];
  logic [ProdBits-1:0] crem_m [WordBits+1];
  logic [WordBits-1:0] cnq_m  [WordBits+1];
  logic [ProdBits-1:0] cdiv_m [WordBits+1];

  // Advance when the output register is empty or drains this cycle
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  tbp_front #(
    .WordBits     (WordBits),
    .FractionBits (FractionBits),
    .ProdBits     (ProdBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_i.valid),
    .son_up_i   (in_i.son_up_value),
    .son_mid_i  (in_i.son_mid_value),
    .son_down_i (in_i.son_down_value),
    .expected_i (in_i.expected_value),
    .variance_i (in_i.local_variance),
    .valid_o    (cv[0]),
    .flags_o    (cf[0]),
    .rem_up_o   (crem_u[0]),
    .nq_up_o    (cnq_u[0]),
    .div_up_o   (cdiv_u[0]),
    .rem_mid_o  (crem_m[0]),
    .nq_mid_o   (cnq_m[0]),
    .div_mid_o  (cdiv_m[0])
  );

  for (genvar k = 0; k < WordBits; k++) begin : g_cell
    tbp_div_cell #(
      .WordBits (WordBits),
      .ProdBits (ProdBits)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .valid_i   (cv[k]),
      .flags_i   (cf[k]),
      .rem_up_i  (crem_u[k]),
      .nq_up_i   (cnq_u[k]),
      .div_up_i  (cdiv_u[k]),
      .rem_mid_i (crem_m[k]),
      .nq_mid_i  (cnq_m[k]),
      .div_mid_i (cdiv_m[k]),
      .valid_o   (cv[k+1]),
      .flags_o   (cf[k+1]),
      .rem_up_o  (crem_u[k+1]),
      .nq_up_o   (cnq_u[k+1]),
      .div_up_o  (cdiv_u[k+1]),
      .rem_mid_o (crem_m[k+1]),
      .nq_mid_o  (cnq_m[k+1]),
      .div_mid_o (cdiv_m[k+1])
    );
  end

  tbp_finish #(
    .WordBits     (WordBits),
    .FractionBits (FractionBits)
  ) u_finish (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (cv[WordBits]),
    .flags_i      (cf[WordBits]),
    .q_up_i       (cnq_u[WordBits]),
    .q_mid_i      (cnq_m[WordBits]),
    .valid_o      (out_o.valid),
    .prob_up_o    (out_o.prob_up),
    .prob_mid_o   (out_o.prob_mid),
    .prob_down_o  (out_o.prob_down),
    .negative_o   (out_o.negative_flag),
    .degenerate_o (out_o.degenerate_flag)
  );

endmodule

@@ design/tbp_checker.sv @@
module tbp_checker #(
  parameter int unsigned WordBits = tbp_pkg::WORD_BITS
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [WordBits-1:0] prob_up_i,
  input logic signed [WordBits-1:0] prob_mid_i,
  input logic signed [WordBits-1:0] prob_down_i,
  input logic                       negative_i,
  input logic                       degenerate_i
);

  // Check the first edge after reset release: the output must come up empty
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("result offered right after reset");

  a_degenerate_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && degenerate_i |->
      prob_up_i == '0 && prob_mid_i == '0 && prob_down_i == '0 && !negative_i)
    else $error("degenerate result carries nonzero fields");

  a_negative_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !degenerate_i |->
      negative_i == (prob_up_i[WordBits-1] | prob_mid_i[WordBits-1] |
                     prob_down_i[WordBits-1]))
    else $error("negative flag disagrees with probability signs");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(prob_up_i) && $stable(prob_mid_i) && $stable(prob_down_i))
    else $error("stalled result changed");

endmodule

bind trinomial_branch_probabilities_top tbp_checker #(
  .WordBits (WordBits)
) u_tbp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .prob_up_i    (out_o.prob_up),
  .prob_mid_i   (out_o.prob_mid),
  .prob_down_i  (out_o.prob_down),
  .negative_i   (out_o.negative_flag),
  .degenerate_i (out_o.degenerate_flag)
);
